// File: design/dfm_pkg.sv
`default_nettype none

package dfm_pkg;

	localparam logic [7:0] DLE_BYTE = 8'h10;
	localparam logic [7:0] ETX_BYTE = 8'h03;
	localparam logic [7:0] FRAME_ID = 8'hC1;

	// body positions: 0 pad, 1 type, 2 signal, 3..6 seconds, 7..10 nanoseconds
	localparam logic [4:0] POS_TYPE     = 5'd1;
	localparam logic [4:0] POS_SIGNAL   = 5'd2;
	localparam logic [4:0] POS_SEC_LO   = 5'd3;
	localparam logic [4:0] POS_SEC_HI   = 5'd6;
	localparam logic [4:0] POS_NS_LO    = 5'd7;
	localparam logic [4:0] POS_NS_HI    = 5'd10;
	localparam logic [4:0] HEADER_BYTES = 5'd11;
	localparam logic [4:0] POS_MAX      = 5'd31;

	localparam logic [1:0] KIND_MODE_AC = 2'd0;
	localparam logic [1:0] KIND_SHORT   = 2'd1;
	localparam logic [1:0] KIND_LONG    = 2'd2;

	localparam int IDX_W = 4;
	localparam int TS_W  = 62;
	localparam logic [29:0] NS_PER_SEC = 30'd1000000000;

	typedef struct packed {
		logic [1:0]  kind;
		logic        crc;
		logic [7:0]  signal;
		logic [31:0] seconds;
		logic [31:0] nanos;
	} hdr_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
		logic [7:0]       data;
	} wr_t;

	function automatic logic [4:0] kind_length(input logic [1:0] kind);
		logic [4:0] len;
		case (kind)
			KIND_MODE_AC: len = 5'd2;
			KIND_SHORT:   len = 5'd7;
			default:      len = 5'd14;
		endcase
		return len;
	endfunction

endpackage

`default_nettype wire

// File: design/dfm_frame_rx.sv
`default_nettype none

module dfm_frame_rx
	import dfm_pkg::*;
#(
	parameter int MAX_PAYLOAD_BYTES = 14
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       xfer,
	input  wire logic [7:0] rx_byte,
	input  wire logic       accept_mode_ac,
	output hdr_t            hdr,
	output wr_t             wr,
	output logic            close_ok
);

	localparam logic [1:0] PH_HUNT = 2'd0;
	localparam logic [1:0] PH_LEAD = 2'd1;
	localparam logic [1:0] PH_BODY = 2'd2;
	localparam logic [1:0] PH_ESC  = 2'd3;
	localparam logic [4:0] MAX_LEN = 5'(MAX_PAYLOAD_BYTES);

	logic [1:0] phase_q;
	logic [4:0] pos_q;
	logic       valid_q;
	hdr_t       hdr_q;

	logic       take;
	logic [4:0] pay_pos;
	logic [4:0] len;

	assign take = xfer && (((phase_q == PH_BODY) && (rx_byte != DLE_BYTE)) ||
		((phase_q == PH_ESC) && (rx_byte != ETX_BYTE)));
	assign pay_pos = pos_q - HEADER_BYTES;
	assign len = kind_length(hdr_q.kind);

	assign close_ok = xfer && (phase_q == PH_ESC) && (rx_byte == ETX_BYTE) && valid_q &&
		!((hdr_q.kind == KIND_MODE_AC) && !accept_mode_ac) && (len <= MAX_LEN) &&
		(pos_q >= HEADER_BYTES + len);

	assign wr = '{
		en:   take && (pos_q >= HEADER_BYTES) && (pay_pos < MAX_LEN),
		addr: pay_pos[IDX_W-1:0],
		data: rx_byte
	};
	assign hdr = hdr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			pos_q   <= '0;
			valid_q <= 1'b0;
			hdr_q   <= '0;
		end else if (xfer) begin
			unique case (phase_q)
				PH_HUNT: begin
					if (rx_byte == DLE_BYTE)
						phase_q <= PH_LEAD;
				end
				PH_LEAD: begin
					if (rx_byte == ETX_BYTE) begin
						phase_q <= PH_HUNT;
					end else if (rx_byte != DLE_BYTE) begin
						valid_q    <= (rx_byte == FRAME_ID);
						pos_q      <= '0;
						hdr_q.kind <= KIND_MODE_AC;
						hdr_q.crc  <= 1'b0;
						phase_q    <= PH_BODY;
					end
				end
				PH_BODY: begin
					if (rx_byte == DLE_BYTE)
						phase_q <= PH_ESC;
				end
				PH_ESC: begin
					phase_q <= (rx_byte == ETX_BYTE) ? PH_HUNT : PH_BODY;
				end
				default: phase_q <= PH_HUNT;
			endcase

			if (take) begin
				if (pos_q == POS_TYPE) begin
					hdr_q.crc <= rx_byte[4];
					if (rx_byte[3:0] > 4'd2) begin
						valid_q <= 1'b0;
					end else begin
						hdr_q.kind <= rx_byte[1:0];
						if (kind_length(rx_byte[1:0]) > MAX_LEN)
							valid_q <= 1'b0;
					end
				end else if (pos_q == POS_SIGNAL) begin
					hdr_q.signal <= rx_byte;
				end else if ((pos_q >= POS_SEC_LO) && (pos_q <= POS_SEC_HI)) begin
					hdr_q.seconds <= {hdr_q.seconds[23:0], rx_byte};
				end else if ((pos_q >= POS_NS_LO) && (pos_q <= POS_NS_HI)) begin
					hdr_q.nanos <= {hdr_q.nanos[23:0], rx_byte};
				end
				if (pos_q != POS_MAX)
					pos_q <= pos_q + 5'd1;
			end
		end
	end

endmodule

`default_nettype wire

// File: design/dle_framed_message_deframer.sv
// dle-stuffed frame deframer for type c1 frames (mode a/c, short and long mode s)
// input stream: one raw byte per transfer on s_tdata; a frame opens with dle and an
// id byte, closes on an unescaped dle etx, and dle inside the frame escapes the
// next byte. frames with a foreign id, unknown type, too few bytes or mode a/c
// while accept_mode_ac is low are dropped silently.
// output stream: on a good close the 2, 7 or 14 payload bytes come out one per
// transfer with kind and crc flag on m_tuser, signal power, timestamp in ns,
// byte index and data on m_tdata, and m_tlast on the final byte.
// throughput: one input byte per cycle while parsing. after the closing etx the
// input is held off for the timestamp work (a 32 x 30 bit multiply, then the
// add of the nanoseconds), then while the payload memory is read out, so the
// next frame is not taken until the last payload byte has been loaded out.
// the first payload byte is registered out in the emit state after the add.
// if the receiver stalls, the output register holds its transfer and the
// read-out waits; no byte is lost.
// reset clears the parser to hunting for a start dle and drops any frame in
// flight; accept_mode_ac resets to 0. the payload memory needs no clearing.
`default_nettype none

module dle_framed_message_deframer
	import dfm_pkg::*;
#(
	parameter int MAX_PAYLOAD_BYTES = 14
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_wdata,   // accept_mode_ac
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,     // rx_byte
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [95:0]      m_tdata,     // signal_power, timestamp_ns, byte_index, data_byte
	output logic [2:0]       m_tuser,     // msg_kind, crc_present
	output logic             m_tlast      // last
);

	localparam int ADDR_W = $clog2(MAX_PAYLOAD_BYTES);
	localparam logic [IDX_W-1:0] MAX_IDX = IDX_W'(MAX_PAYLOAD_BYTES);

	localparam logic [1:0] ST_PARSE = 2'd0;
	localparam logic [1:0] ST_MUL   = 2'd1;
	localparam logic [1:0] ST_ADD   = 2'd2;
	localparam logic [1:0] ST_EMIT  = 2'd3;

	logic [1:0]       state_q;
	logic             acc_ac_q;
	hdr_t             hdr;
	wr_t              wr;
	logic             close_ok;

	logic [7:0]       mem [MAX_PAYLOAD_BYTES];
	logic [7:0]       rd_data_q;
	logic [IDX_W-1:0] rd_addr;
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] last_idx_q;
	logic             load;

	logic [TS_W-1:0]  prod_s1;
	logic [15:0]      power_s1;
	logic [TS_W-1:0]  ts_s2;

	logic             out_valid_q;
	logic [1:0]       out_kind_q;
	logic             out_crc_q;
	logic [15:0]      out_power_q;
	logic [TS_W-1:0]  out_ts_q;
	logic [IDX_W-1:0] out_idx_q;
	logic [7:0]       out_data_q;
	logic             out_last_q;

	assign s_tready = (state_q == ST_PARSE);

	dfm_frame_rx #(
		.MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES)
	) u_rx (
		.clk            (clk),
		.arst_n         (arst_n),
		.xfer           (s_tvalid && s_tready),
		.rx_byte        (s_tdata),
		.accept_mode_ac (acc_ac_q),
		.hdr            (hdr),
		.wr             (wr),
		.close_ok       (close_ok)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			acc_ac_q <= 1'b0;
		else if (cfg_we)
			acc_ac_q <= cfg_wdata;
	end

	// payload memory; the read address runs one ahead when a byte is loaded out
	assign load = (state_q == ST_EMIT) && (!out_valid_q || m_tready);
	assign rd_addr = load ? idx_q + IDX_W'(1) : idx_q;

	always_ff @(posedge clk) begin
		if (wr.en)
			mem[wr.addr[ADDR_W-1:0]] <= wr.data;
		if (rd_addr < MAX_IDX)
			rd_data_q <= mem[rd_addr[ADDR_W-1:0]];
	end

	// timestamp: multiply, register, then add; the signal power is squared alongside the multiply
	always_ff @(posedge clk) begin
		if (state_q == ST_MUL) begin
			prod_s1  <= TS_W'(hdr.seconds) * TS_W'(NS_PER_SEC);
			power_s1 <= 16'(hdr.signal) * 16'(hdr.signal);
		end
		if (state_q == ST_ADD)
			ts_s2 <= prod_s1 + TS_W'(hdr.nanos);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_PARSE;
			idx_q      <= '0;
			last_idx_q <= '0;
		end else begin
			unique case (state_q)
				ST_PARSE: begin
					if (close_ok) begin
						idx_q      <= '0;
						last_idx_q <= IDX_W'(kind_length(hdr.kind) - 5'd1);
						state_q    <= ST_MUL;
					end
				end
				ST_MUL:  state_q <= ST_ADD;
				ST_ADD:  state_q <= ST_EMIT;
				ST_EMIT: begin
					if (load) begin
						idx_q <= idx_q + IDX_W'(1);
						if (idx_q == last_idx_q)
							state_q <= ST_PARSE;
					end
				end
				default: state_q <= ST_PARSE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (load)
			out_valid_q <= 1'b1;
		else if (m_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_kind_q  <= hdr.kind;
			out_crc_q   <= hdr.crc;
			out_power_q <= power_s1;
			out_ts_q    <= ts_s2;
			out_idx_q   <= idx_q;
			out_data_q  <= rd_data_q;
			out_last_q  <= (idx_q == last_idx_q);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'b0, out_data_q, out_idx_q, out_ts_q, out_power_q};
	assign m_tuser  = {out_crc_q, out_kind_q};
	assign m_tlast  = out_last_q;

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import dfm_pkg::*;

	localparam int PAYLOAD_MAX = 14;
	localparam int LONG_STALL = 400;
	localparam int SETTLE_CYCLES = 40;
	localparam int CYCLE_LIMIT = 200000;

	typedef enum logic [1:0] {P_HUNT, P_LEAD, P_BODY, P_ESC} parse_phase_t;

	// one payload byte as it leaves the block
	typedef struct packed {
		logic [1:0]  kind;
		logic        crc;
		logic [15:0] power;
		logic [61:0] ts;
		logic [3:0]  idx;
		logic [7:0]  data;
		logic        last;
	} payload_beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_wdata = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;    // rx_byte
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [95:0] m_tdata;            // signal_power, timestamp_ns, byte_index, data_byte, pad
	logic [2:0]  m_tuser;            // msg_kind, crc_present
	logic        m_tlast;            // last

	dle_framed_message_deframer u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// deframer shadow state
	parse_phase_t ph = P_HUNT;
	logic [4:0]   body_pos = '0;
	logic         frame_ok = 1'b0;
	logic [1:0]   kind_q = KIND_MODE_AC;
	logic         crc_q = 1'b0;
	logic [7:0]   sig_q = '0;
	logic [31:0]  sec_q = '0;
	logic [31:0]  ns_q = '0;
	logic [7:0]   pay_mem [PAYLOAD_MAX];
	logic         accept_ac = 1'b0;

	payload_beat_t payload_beats_due[$];
	logic [7:0]    tx_bytes[$];
	logic [7:0]    body[$];
	int            errors = 0;
	int            cycle_count = 0;
	int            tx_idle_pct = 12;
	int            rx_idle_pct = 86;
	int            stall_request = 0;
	int            stall_served = 0;
	int            stall_left = 0;
	payload_beat_t got, want;

	function automatic int payload_len(input logic [1:0] k);
		case (k)
			KIND_MODE_AC: return 2;
			KIND_SHORT:   return 7;
			default:      return 14;
		endcase
	endfunction

	task automatic absorb_body_byte(input logic [7:0] b);
		logic [4:0] off;
		off = body_pos - HEADER_BYTES;
		if (body_pos == POS_TYPE) begin
			crc_q = b[4];
			if (b[3:0] > 4'd2)
				frame_ok = 1'b0;
			else
				kind_q = b[1:0];
		end else if (body_pos == POS_SIGNAL) begin
			sig_q = b;
		end else if (body_pos >= POS_SEC_LO && body_pos <= POS_SEC_HI) begin
			sec_q = {sec_q[23:0], b};
		end else if (body_pos >= POS_NS_LO && body_pos <= POS_NS_HI) begin
			ns_q = {ns_q[23:0], b};
		end else if (body_pos >= HEADER_BYTES && int'(off) < PAYLOAD_MAX) begin
			pay_mem[off[3:0]] = b;
		end
		if (body_pos != POS_MAX)
			body_pos = body_pos + 5'd1;
	endtask

	task automatic emit_payload();
		int n;
		logic [63:0] ts;
		payload_beat_t beat;
		n = payload_len(kind_q);
		if (!frame_ok || (kind_q == KIND_MODE_AC && !accept_ac))
			return;
		if (int'(body_pos) < int'(HEADER_BYTES) + n)
			return;
		ts = {32'd0, sec_q} * 64'd1000000000 + {32'd0, ns_q};
		for (int j = 0; j < n; j++) begin
			beat.kind = kind_q;
			beat.crc = crc_q;
			beat.power = {8'd0, sig_q} * {8'd0, sig_q};
			beat.ts = ts[61:0];
			beat.idx = j[3:0];
			beat.data = pay_mem[j[3:0]];
			beat.last = (j == n - 1);
			payload_beats_due.push_back(beat);
		end
	endtask

	task automatic parse_rx_byte(input logic [7:0] b);
		case (ph)
			P_HUNT: begin
				if (b == DLE_BYTE)
					ph = P_LEAD;
			end
			P_LEAD: begin
				// a repeated dle keeps waiting for the id byte
				if (b == ETX_BYTE) begin
					ph = P_HUNT;
				end else if (b != DLE_BYTE) begin
					frame_ok = (b == FRAME_ID);
					body_pos = '0;
					kind_q = KIND_MODE_AC;
					crc_q = 1'b0;
					ph = P_BODY;
				end
			end
			P_BODY: begin
				if (b == DLE_BYTE)
					ph = P_ESC;
				else
					absorb_body_byte(b);
			end
			default: begin
				if (b == ETX_BYTE) begin
					ph = P_HUNT;
					emit_payload();
				end else begin
					absorb_body_byte(b);
					ph = P_BODY;
				end
			end
		endcase
	endtask

	// byte source
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				parse_rx_byte(s_tdata);
			if (!s_tvalid || s_tready) begin
				if (tx_bytes.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
					s_tvalid <= 1'b1;
					s_tdata <= tx_bytes.pop_front();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// payload sink, with an occasional long hold-off
	always @(posedge clk) begin
		if (stall_request != stall_served) begin
			stall_served <= stall_request;
			stall_left <= LONG_STALL;
			m_tready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got.kind = m_tuser[1:0];
			got.crc = m_tuser[2];
			got.power = m_tdata[15:0];
			got.ts = m_tdata[77:16];
			got.idx = m_tdata[81:78];
			got.data = m_tdata[89:82];
			got.last = m_tlast;
			if (payload_beats_due.size() == 0) begin
				$display("%0t: unexpected payload transfer, got kind %0d idx %0d data %h",
					$time, got.kind, got.idx, got.data);
				errors++;
			end else begin
				want = payload_beats_due.pop_front();
				if (got.kind != want.kind || got.crc != want.crc || got.power != want.power ||
						got.ts != want.ts || got.idx != want.idx || got.data != want.data ||
						got.last != want.last) begin
					$display("%0t: mismatch, expected kind %0d crc %0d pwr %0d ts %0d idx %0d data %h last %0d",
						$time, want.kind, want.crc, want.power, want.ts, want.idx, want.data,
						want.last);
					$display("%0t:              got kind %0d crc %0d pwr %0d ts %0d idx %0d data %h last %0d",
						$time, got.kind, got.crc, got.power, got.ts, got.idx, got.data, got.last);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// biased towards the stuffing byte, etx and the extremes
	function automatic logic [7:0] rand_byte();
		case ($urandom_range(7))
			0:       return DLE_BYTE;
			1:       return 8'h00;
			2:       return 8'hFF;
			3:       return ETX_BYTE;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	task automatic make_body(input logic [7:0] ty, input logic [7:0] sig,
			input logic [31:0] sec, input logic [31:0] ns, input int n_pay);
		body.delete();
		body.push_back(rand_byte());
		body.push_back(ty);
		body.push_back(sig);
		for (int i = 3; i >= 0; i--)
			body.push_back(sec[8*i +: 8]);
		for (int i = 3; i >= 0; i--)
			body.push_back(ns[8*i +: 8]);
		repeat (n_pay)
			body.push_back(rand_byte());
	endtask

	// stuffs the body; with esc_extra some ordinary bytes get a needless escape too
	task automatic send_frame(input logic [7:0] id, input bit esc_extra);
		tx_bytes.push_back(DLE_BYTE);
		tx_bytes.push_back(id);
		foreach (body[i]) begin
			if (body[i] == DLE_BYTE ||
					(esc_extra && body[i] != ETX_BYTE && $urandom_range(4) == 0))
				tx_bytes.push_back(DLE_BYTE);
			tx_bytes.push_back(body[i]);
		end
		tx_bytes.push_back(DLE_BYTE);
		tx_bytes.push_back(ETX_BYTE);
	endtask

	task automatic random_frame();
		int pick, cut;
		logic [1:0] kind;
		logic [3:0] nib, hi;
		logic [7:0] id;
		logic [31:0] sec, ns;
		pick = $urandom_range(99);
		kind = 2'($urandom_range(2));
		hi = 4'($urandom_range(15));
		nib = (pick >= 76 && pick < 82) ? 4'($urandom_range(3, 15)) : {2'b00, kind};
		sec = ($urandom_range(3) == 0) ? 32'hFFFF_FFFF : $urandom();
		ns = ($urandom_range(3) == 0) ? 32'hFFFF_FFFF : $urandom();
		make_body({hi, nib}, rand_byte(), sec, ns, payload_len(kind));
		id = FRAME_ID;
		if (pick < 60) begin
			send_frame(id, 1'($urandom_range(1)));
		end else if (pick < 68) begin
			cut = $urandom_range(body.size() - 1);
			while (body.size() > cut)
				void'(body.pop_back());
			send_frame(id, 1'b0);
		end else if (pick < 76) begin
			repeat ($urandom_range(1, 25))
				body.push_back(rand_byte());
			send_frame(id, 1'b1);
		end else if (pick < 82) begin
			send_frame(id, 1'b0);
		end else if (pick < 88) begin
			do
				id = 8'($urandom_range(255));
			while (id == FRAME_ID || id == DLE_BYTE || id == ETX_BYTE);
			send_frame(id, 1'b0);
		end else if (pick < 94) begin
			// line noise, may leave the parser mid-frame
			repeat ($urandom_range(1, 8))
				tx_bytes.push_back(rand_byte());
		end else begin
			tx_bytes.push_back(DLE_BYTE);
			tx_bytes.push_back($urandom_range(1) ? DLE_BYTE : ETX_BYTE);
			send_frame(id, 1'b0);
		end
	endtask

	task automatic wait_all_delivered();
		while (tx_bytes.size() != 0 || s_tvalid || payload_beats_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_accept_mode_ac(input logic v);
		wait_all_delivered();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		accept_ac = v;
	endtask

	task automatic random_burst(input int n_bytes);
		while (tx_bytes.size() < n_bytes)
			random_frame();
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// mode a/c still disabled out of reset
		tx_bytes.push_back(8'h00);
		tx_bytes.push_back(8'hFF);
		tx_bytes.push_back(ETX_BYTE);
		tx_bytes.push_back(FRAME_ID);
		tx_bytes.push_back(8'h7E);
		// dle etx with no id, then a long frame at full scale
		tx_bytes.push_back(DLE_BYTE);
		tx_bytes.push_back(ETX_BYTE);
		make_body(8'h12, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 14);
		send_frame(FRAME_ID, 1'b0);
		// doubled start dle, short frame at zero
		tx_bytes.push_back(DLE_BYTE);
		make_body(8'h01, 8'h00, 32'h0, 32'h0, 7);
		send_frame(FRAME_ID, 1'b0);
		make_body(8'h00, 8'h80, $urandom(), $urandom(), 2);
		send_frame(FRAME_ID, 1'b0);
		make_body(8'h01, 8'h55, $urandom(), $urandom(), 7);
		send_frame(8'hC2, 1'b0);
		make_body(8'h0F, 8'h55, $urandom(), $urandom(), 2);
		send_frame(FRAME_ID, 1'b0);
		make_body(8'h01, 8'h33, $urandom(), $urandom(), 5);
		send_frame(FRAME_ID, 1'b0);
		// over-long, pushes the position count into saturation
		make_body(8'h11, 8'h01, $urandom(), $urandom(), 21);
		send_frame(FRAME_ID, 1'b0);
		make_body(8'h02, 8'hA5, $urandom(), $urandom(), 14);
		send_frame(FRAME_ID, 1'b1);

		set_accept_mode_ac(1'b1);
		make_body(8'h10, DLE_BYTE, 32'h1010_1010, 32'h0000_0001, 2);
		send_frame(FRAME_ID, 1'b0);
		make_body(8'hE0, 8'hFE, $urandom(), $urandom(), 2);
		send_frame(FRAME_ID, 1'b1);

		set_accept_mode_ac(1'b0);
		tx_idle_pct <= 86;
		rx_idle_pct <= 12;
		random_burst(30);

		set_accept_mode_ac(1'b1);
		tx_idle_pct <= 0;
		rx_idle_pct <= 0;
		stall_request <= stall_request + 1;
		make_body(8'h02, 8'h5A, $urandom(), $urandom(), 14);
		send_frame(FRAME_ID, 1'b0);
		random_frame();
		random_frame();
		// sender holds back until the block has emptied
		wait_all_delivered();

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// File: dle_framed_message_deframer.f
design/dfm_pkg.sv
design/dfm_frame_rx.sv
design/dle_framed_message_deframer.sv
tb/sv/tb.sv
